>>> hdl/cfs_pkg.sv
// Shared types, codes and reset values of the coupled field stencil engine.
package cfs_pkg;

  typedef struct packed {
    logic signed [31:0] field_zero;
    logic signed [31:0] field_one;
    logic signed [31:0] field_two;
    logic               frame_start;
  } src_item_t;

  typedef struct packed {
    logic signed [31:0] accel_zero;
    logic signed [31:0] accel_one;
    logic signed [31:0] accel_two;
    logic [9:0]         centre_row;
    logic [9:0]         centre_col;
    logic               saturated;
  } res_item_t;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X,
    CFG_COEF_Y,
    CFG_MASS_SQ,
    CFG_TRIPLE_STRENGTH,
    CFG_TRIPLE_SOFTEN,
    CFG_PAIR_GAIN,
    CFG_CROSS_GAIN,
    CFG_ROW_LENGTH
  } cfg_idx_t;

  localparam logic [30:0]        RST_COEF_X          = 31'd681836544;
  localparam logic [30:0]        RST_COEF_Y          = 31'd681836544;
  localparam logic [30:0]        RST_MASS_SQ         = 31'd16777216;
  localparam logic signed [31:0] RST_TRIPLE_STRENGTH = -32'sd335544320;
  localparam logic [30:0]        RST_TRIPLE_SOFTEN   = 31'd335544320;
  localparam logic signed [31:0] RST_PAIR_GAIN       = 32'sd16609444;
  localparam logic signed [31:0] RST_CROSS_GAIN      = 32'sd0;
  localparam logic [10:0]        RST_ROW_LENGTH      = 11'd256;

  // Sequence of products run on the shared multiplier, in issue order.
  typedef enum logic [4:0] {
    OP_Q01, OP_Q02, OP_Q12, OP_P, OP_P2, OP_K, OP_D2,
    OP_T0, OP_U0, OP_F0, OP_T1, OP_U1, OP_F1, OP_T2, OP_U2, OP_F2,
    OP_LX0, OP_LY0, OP_LM0, OP_LP0,
    OP_LX1, OP_LY1, OP_LM1, OP_LP1,
    OP_LX2, OP_LY2, OP_LM2, OP_LP2,
    OP_C0, OP_C1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic clear;
    logic mul_start;
    logic div_start;
    logic load_out;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic mul_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> hdl/cfs_ctrl.sv
// Sequencer: steps one transaction through window load, products, division and output.
module cfs_ctrl import cfs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    src_valid,
  output logic    src_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_Q01;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign src_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        if (src_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.shift = 1'b1;
        cmd.clear = 1'b1;
        if (status.emit) begin
          op_next    = OP_Q01;
          state_next = S_MUL_GO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          priority if (op == OP_D2) begin
            state_next = S_DIV_GO;
          end else if (op == OP_C1) begin
            state_next = S_OUT;
          end else begin
            op_next    = op_t'(op + 5'd1);
            state_next = S_MUL_GO;
          end
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          op_next    = OP_T0;
          state_next = S_MUL_GO;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/cfs_datapath.sv
// Datapath: row memory, 3x3 windows, shared multiplier, divider, accumulators, output register.
module cfs_datapath import cfs_pkg::*; #(
  parameter int MAX_ROW_LEN = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  src_item_t            src_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_item_t            res_item
);

  localparam int CW    = $clog2(MAX_ROW_LEN);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int LW    = 13;
  localparam int CXC   = (CW > 10) ? CW : 10;
  localparam int CXR   = (RW > 10) ? RW : 10;

  localparam logic [63:0]  LIM36  = 64'd1 << 36;
  localparam logic [63:0]  LIM44  = 64'd1 << 44;
  localparam logic [63:0]  LIM62  = 64'd1 << 62;
  localparam logic [127:0] HALF24 = 128'd1 << 23;
  localparam logic [127:0] HALF38 = 128'd1 << 37;
  localparam logic [37:0]  ONE_Q24 = 38'd1 << 24;
  localparam logic [37:0]  DEN_LIM = 38'd1 << 36;

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [32:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return {1'b1, 32'h7fffffff};
    else if (v < -48'sd2147483648) return {1'b1, 32'h80000000};
    else return {1'b0, v[31:0]};
  endfunction

  // configuration
  logic [30:0]        coef_x, coef_y, mass_sq, triple_soften;
  logic signed [31:0] triple_strength, pair_gain, cross_gain;
  logic [10:0]        row_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x          <= RST_COEF_X;
      coef_y          <= RST_COEF_Y;
      mass_sq         <= RST_MASS_SQ;
      triple_strength <= RST_TRIPLE_STRENGTH;
      triple_soften   <= RST_TRIPLE_SOFTEN;
      pair_gain       <= RST_PAIR_GAIN;
      cross_gain      <= RST_CROSS_GAIN;
      row_length      <= RST_ROW_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_X:          coef_x          <= cfg_data[30:0];
        CFG_COEF_Y:          coef_y          <= cfg_data[30:0];
        CFG_MASS_SQ:         mass_sq         <= cfg_data[30:0];
        CFG_TRIPLE_STRENGTH: triple_strength <= $signed(cfg_data);
        CFG_TRIPLE_SOFTEN:   triple_soften   <= cfg_data[30:0];
        CFG_PAIR_GAIN:       pair_gain       <= $signed(cfg_data);
        CFG_CROSS_GAIN:      cross_gain      <= $signed(cfg_data);
        CFG_ROW_LENGTH:      row_length      <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // raster position
  logic [CW-1:0] col_count, c_cur, col_next;
  logic [RW-1:0] row_count, r_cur, row_next;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [LW-1:0] len_eff;
  logic          emit_now;

  always_comb begin
    r_cur = src_item.frame_start ? '0 : row_count;
    c_cur = src_item.frame_start ? '0 : col_count;
    priority if (LW'(row_length) < LW'(3)) len_eff = LW'(3);
    else if (LW'(row_length) > LW'(MAX_ROW_LEN)) len_eff = LW'(MAX_ROW_LEN);
    else len_eff = LW'(row_length);
    col_inc  = {1'b0, c_cur} + (CW+1)'(1);
    row_inc  = {1'b0, r_cur} + (RW+1)'(1);
    row_next = r_cur;
    col_next = col_inc[CW-1:0];
    if (LW'(col_inc) >= len_eff) begin
      col_next = '0;
      row_next = (row_inc >= (RW+1)'(MAX_ROWS)) ? '0 : row_inc[RW-1:0];
    end
    emit_now = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
  end

  logic [RW-1:0] r_lat;
  logic [CW-1:0] c_lat;
  logic          emit_lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      emit_lat  <= 1'b0;
    end else if (cmd.accept) begin
      row_count <= row_next;
      col_count <= col_next;
      emit_lat  <= emit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_lat <= r_cur;
      c_lat <= c_cur;
    end
  end

  // row buffers: bank r&1 holds row r, all three fields side by side
  logic [95:0]   rowmem [DEPTH];
  logic [95:0]   rd_old, rd_mid, v_word;
  logic [AW-1:0] addr_old, addr_mid;

  assign addr_old = {r_cur[0], c_cur};
  assign addr_mid = {~r_cur[0], c_cur};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rowmem[addr_old] <= {src_item.field_two, src_item.field_one, src_item.field_zero};
      rd_old <= rowmem[addr_old];
      rd_mid <= rowmem[addr_mid];
      v_word <= {src_item.field_two, src_item.field_one, src_item.field_zero};
    end
  end

  // window [field][row][column]
  logic signed [31:0] win [3][3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < 3; f++)
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++)
            win[f][k][j] <= '0;
    end else if (cmd.shift) begin
      for (int f = 0; f < 3; f++) begin
        for (int k = 0; k < 3; k++) begin
          win[f][k][0] <= win[f][k][1];
          win[f][k][1] <= win[f][k][2];
        end
        win[f][0][2] <= $signed(rd_old[32*f +: 32]);
        win[f][1][2] <= $signed(rd_mid[32*f +: 32]);
        win[f][2][2] <= $signed(v_word[32*f +: 32]);
      end
    end
  end

  logic signed [31:0] cen    [3];
  logic signed [34:0] d2x    [3];
  logic signed [34:0] d2y    [3];
  logic signed [34:0] pd     [3];
  logic signed [34:0] corner [3];

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      cen[f]    = win[f][1][1];
      d2x[f]    = 35'(win[f][0][1]) + 35'(win[f][2][1]) - (35'(win[f][1][1]) <<< 1);
      d2y[f]    = 35'(win[f][1][0]) + 35'(win[f][1][2]) - (35'(win[f][1][1]) <<< 1);
      pd[f]     = (35'(win[f][1][1]) <<< 1) - 35'(win[(f+1)%3][1][1])
                  - 35'(win[(f+2)%3][1][1]);
      corner[f] = 35'(win[f][2][2]) - 35'(win[f][2][0]) - 35'(win[f][0][2])
                  + 35'(win[f][0][0]);
    end
  end

  // intermediate products
  logic signed [39:0] q01, q02, q12;
  logic signed [46:0] p;
  logic [36:0]        p2, d;
  logic [48:0]        d2;
  logic signed [63:0] tu;
  logic signed [47:0] acc [3];
  logic               sat_acc;

  // operand selection
  logic signed [63:0] op_a, op_b, neg_mu;
  logic               s38;
  logic [63:0]        lim;
  logic [38:0]        recip;

  assign neg_mu = -64'(triple_strength);

  always_comb begin
    op_a = '0;
    op_b = '0;
    s38  = 1'b0;
    lim  = LIM62;
    unique case (cmd.op)
      OP_Q01: begin op_a = 64'(cen[0]); op_b = 64'(cen[1]); end
      OP_Q02: begin op_a = 64'(cen[0]); op_b = 64'(cen[2]); end
      OP_Q12: begin op_a = 64'(cen[1]); op_b = 64'(cen[2]); end
      OP_P:   begin op_a = 64'(q01); op_b = 64'(cen[2]); end
      OP_P2:  begin op_a = 64'(p); op_b = 64'(p); lim = LIM36; end
      OP_K:   begin op_a = 64'(triple_soften); op_b = 64'(p2); lim = LIM36; end
      OP_D2:  begin op_a = 64'(d); op_b = 64'(d); end
      OP_T0:  begin op_a = 64'(p); op_b = 64'(q12); end
      OP_T1:  begin op_a = 64'(p); op_b = 64'(q02); end
      OP_T2:  begin op_a = 64'(p); op_b = 64'(q01); end
      OP_U0, OP_U1, OP_U2: begin op_a = tu; op_b = 64'(recip); s38 = 1'b1; end
      OP_F0, OP_F1, OP_F2: begin op_a = neg_mu; op_b = tu; lim = LIM44; end
      OP_LX0: begin op_a = 64'(d2x[0]); op_b = 64'(coef_x); end
      OP_LY0: begin op_a = 64'(d2y[0]); op_b = 64'(coef_y); end
      OP_LM0: begin op_a = 64'(cen[0]); op_b = 64'(mass_sq); end
      OP_LP0: begin op_a = 64'(pd[0]); op_b = 64'(pair_gain); end
      OP_LX1: begin op_a = 64'(d2x[1]); op_b = 64'(coef_x); end
      OP_LY1: begin op_a = 64'(d2y[1]); op_b = 64'(coef_y); end
      OP_LM1: begin op_a = 64'(cen[1]); op_b = 64'(mass_sq); end
      OP_LP1: begin op_a = 64'(pd[1]); op_b = 64'(pair_gain); end
      OP_LX2: begin op_a = 64'(d2x[2]); op_b = 64'(coef_x); end
      OP_LY2: begin op_a = 64'(d2y[2]); op_b = 64'(coef_y); end
      OP_LM2: begin op_a = 64'(cen[2]); op_b = 64'(mass_sq); end
      OP_LP2: begin op_a = 64'(pd[2]); op_b = 64'(pair_gain); end
      OP_C0:  begin op_a = 64'(corner[1]); op_b = 64'(cross_gain); end
      OP_C1:  begin op_a = 64'(corner[0]); op_b = 64'(cross_gain); end
      default: ;
    endcase
  end

  // shared multiplier: four 32x32 partial products, then round and clamp
  logic [63:0]        ma, mb;
  logic               mneg, mbusy, mdone;
  logic [2:0]         mcnt;
  logic [127:0]       prod, rnd, qv;
  logic [63:0]        pp;
  logic [1:0]         psh;
  logic               clamp;
  logic [62:0]        mag;
  logic signed [63:0] res;
  logic [37:0]        dsum;

  always_comb begin
    pp    = ma[{mcnt[1], 5'd0} +: 32] * mb[{mcnt[0], 5'd0} +: 32];
    psh   = {1'b0, mcnt[1]} + {1'b0, mcnt[0]};
    rnd   = prod + (s38 ? HALF38 : HALF24);
    qv    = s38 ? (rnd >> 38) : (rnd >> 24);
    clamp = qv > 128'(lim);
    mag   = clamp ? lim[62:0] : qv[62:0];
    res   = mneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    dsum  = 38'(mag[36:0]) + ONE_Q24;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mcnt  <= '0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mcnt  <= '0;
      end else if (mbusy) begin
        mcnt <= mcnt + 3'd1;
        if (mcnt == 3'd4) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma   <= umag(op_a);
      mb   <= umag(op_b);
      mneg <= op_a[63] ^ op_b[63];
      prod <= '0;
    end else if (mbusy && mcnt != 3'd4) begin
      prod <= prod + (128'(pp) << {psh, 5'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int f = 0; f < 3; f++) acc[f] <= '0;
      sat_acc <= 1'b0;
    end else if (mbusy && mcnt == 3'd4) begin
      unique case (cmd.op)
        OP_Q01: q01 <= $signed(res[39:0]);
        OP_Q02: q02 <= $signed(res[39:0]);
        OP_Q12: q12 <= $signed(res[39:0]);
        OP_P:   p   <= $signed(res[46:0]);
        OP_P2: begin
          p2 <= mag[36:0];
          if (clamp) sat_acc <= 1'b1;
        end
        OP_K: begin
          if (clamp || dsum > DEN_LIM) sat_acc <= 1'b1;
          d <= (dsum > DEN_LIM) ? DEN_LIM[36:0] : dsum[36:0];
        end
        OP_D2: d2 <= mag[48:0];
        OP_T0, OP_U0, OP_T1, OP_U1, OP_T2, OP_U2: tu <= res;
        OP_F0, OP_LX0, OP_LY0, OP_C0: acc[0] <= acc[0] + $signed(res[47:0]);
        OP_F1, OP_LX1, OP_LY1, OP_C1: acc[1] <= acc[1] + $signed(res[47:0]);
        OP_F2, OP_LX2, OP_LY2:        acc[2] <= acc[2] + $signed(res[47:0]);
        OP_LM0, OP_LP0: acc[0] <= acc[0] - $signed(res[47:0]);
        OP_LM1, OP_LP1: acc[1] <= acc[1] - $signed(res[47:0]);
        OP_LM2, OP_LP2: acc[2] <= acc[2] - $signed(res[47:0]);
        default: ;
      endcase
    end
  end

  // reciprocal of D^2: restoring division, one quotient bit a cycle
  logic [62:0] dnum;
  logic [48:0] dden, drem;
  logic [49:0] trial;
  logic        qbit, dbusy, ddone;
  logic [5:0]  dcnt;

  always_comb begin
    trial = {drem, dnum[62]};
    qbit  = trial >= {1'b0, dden};
    recip = dnum[38:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
      dcnt  <= '0;
    end else begin
      ddone <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt  <= '0;
      end else if (dbusy) begin
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'd62) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum <= {1'b1, 62'd0} + 63'(d2[48:1]);
      dden <= d2;
      drem <= '0;
    end else if (dbusy) begin
      drem <= qbit ? 49'(trial - {1'b0, dden}) : trial[48:0];
      dnum <= {dnum[61:0], qbit};
    end
  end

  // output register
  logic [32:0]    s0, s1, s2;
  logic [CXR-1:0] cr;
  logic [CXC-1:0] cc;

  always_comb begin
    s0 = sat32(acc[0]);
    s1 = sat32(acc[1]);
    s2 = sat32(acc[2]);
    cr = CXR'(r_lat) - CXR'(1);
    cc = CXC'(c_lat) - CXC'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_item.accel_zero <= $signed(s0[31:0]);
      res_item.accel_one  <= $signed(s1[31:0]);
      res_item.accel_two  <= $signed(s2[31:0]);
      res_item.centre_row <= cr[9:0];
      res_item.centre_col <= cc[9:0];
      res_item.saturated  <= sat_acc | s0[32] | s1[32] | s2[32];
    end
  end

  assign status.emit     = emit_lat;
  assign status.mul_done = mdone;
  assign status.div_done = ddone;
  assign status.out_free = !res_valid || !res_stall;

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mbusy && dbusy))
    else $error("multiplier and divider busy together");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || !res_stall))
    else $error("result loaded over a transaction still waiting");

  a_recip_nonzero: assert property (@(posedge clk) disable iff (rst)
    ddone |-> (recip != '0))
    else $error("reciprocal of denominator is zero");

  a_mul_done_idle: assert property (@(posedge clk) disable iff (rst)
    mdone |-> (!mbusy && !cmd.mul_start))
    else $error("product finished while a new one runs");

endmodule

>>> hdl/coupled_field_stencil_accel.sv
// Top level of the coupled three-field 3x3 stencil engine.
// Operation: a point with a result runs 30 products on one shared 32x32 multiplier and a
// bit-serial divider for the reciprocal of D squared before it reaches the result register;
// a point without a result returns to idle after its window load.
// Throughput: one point at a time; the next is accepted once the previous has cleared.
// Reset (rst, synchronous): clears counters, windows, control and restores registers;
// the row buffers are not cleared.
module coupled_field_stencil_accel import cfs_pkg::*; #(
  parameter int MAX_ROW_LEN = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  src_item_t            src_item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_item_t            res_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t status;

  cfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cfs_datapath #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .src_item  (src_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> dv/tb_coupled_field_stencil_accel.sv
// Self-checking testbench of the coupled three-field stencil engine.
`timescale 1ns / 1ps

module tb_coupled_field_stencil_accel;
  import cfs_pkg::*;

  localparam int  ROW_MAX  = 1024;
  localparam int  ROWS_MAX = 1024;
  localparam longint unsigned DEN_LIM    = 64'd1 << 36;
  localparam longint unsigned WIDE_LIM   = 64'd1 << 62;
  localparam longint unsigned TRIPLE_LIM = 64'd1 << 44;

  logic                 clk;
  logic                 rst;
  logic                 src_valid;
  logic                 src_stall;
  src_item_t            src_item;
  logic                 res_valid;
  logic                 res_stall;
  res_item_t            res_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  coupled_field_stencil_accel dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and stencil state
  logic [30:0]        m_coef_x, m_coef_y, m_mass_sq, m_soften;
  logic signed [31:0] m_strength, m_pair, m_cross;
  logic [10:0]        m_row_len;
  logic signed [31:0] line_buf [3][2*ROW_MAX];
  logic signed [31:0] win [3][3][3];
  int unsigned        row_cnt, col_cnt;

  res_item_t accel_q[$];
  int        errors, n_sent, n_accepted, n_results, n_sat;
  bit        src_took, quiet, typed_on;
  res_item_t typed_res;
  int        stall_left;

  typedef struct {
    src_item_t  it;
    bit         typed;
    res_item_t  res;
  } row_t;
  row_t dir_tab[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("coupled_field_stencil_accel test failed");
    $finish;
  end

  function automatic longint mulq(longint a, longint b, int s, longint unsigned lim,
                                  inout bit sat);
    longint unsigned ua, ub;
    logic [127:0]    p;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    if (p > {64'd0, lim}) begin
      p = {64'd0, lim};
      sat = 1'b1;
    end
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clip32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // advances the stencil state by one grid point; 1 when a centre point is complete
  function automatic bit stencil_step(src_item_t it, output res_item_t res);
    int unsigned        len, r, c, bo, bm;
    logic signed [31:0] v;
    longint             ph[3], lin[3], corner[3], dp[3];
    longint             d2x, d2y, q12, q13, q23, pp, p2, kk, dd, d2, tt, uu, ff, acc;
    longint unsigned    recip;
    bit                 sat, junk, emit;
    res = '0;
    len = m_row_len;
    if (len < 3) len = 3;
    if (len > ROW_MAX) len = ROW_MAX;
    if (it.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt;
    if (c >= ROW_MAX) c = 0;
    bo = (r & 1) * ROW_MAX;
    bm = ((r + 1) & 1) * ROW_MAX;
    for (int f = 0; f < 3; f++) begin
      v = (f == 0) ? it.field_zero : (f == 1) ? it.field_one : it.field_two;
      for (int k = 0; k < 3; k++) begin
        win[f][k][0] = win[f][k][1];
        win[f][k][1] = win[f][k][2];
      end
      win[f][0][2] = line_buf[f][bo + c];
      win[f][1][2] = line_buf[f][bm + c];
      win[f][2][2] = v;
      line_buf[f][bo + c] = v;
    end
    emit = (r >= 2) && (c >= 2);
    col_cnt = c + 1;
    if (col_cnt >= len) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= ROWS_MAX) row_cnt = 0;
    end
    if (!emit) return 1'b0;

    sat = 1'b0;
    for (int f = 0; f < 3; f++) begin
      ph[f] = win[f][1][1];
      d2x = longint'(win[f][0][1]) + win[f][2][1] - 2 * ph[f];
      d2y = longint'(win[f][1][0]) + win[f][1][2] - 2 * ph[f];
      corner[f] = longint'(win[f][2][2]) - win[f][2][0] - win[f][0][2] + win[f][0][0];
      lin[f] = mulq(d2x, longint'(m_coef_x), 24, WIDE_LIM, junk)
             + mulq(d2y, longint'(m_coef_y), 24, WIDE_LIM, junk)
             - mulq(ph[f], longint'(m_mass_sq), 24, WIDE_LIM, junk);
    end
    for (int f = 0; f < 3; f++)
      lin[f] -= mulq(2 * ph[f] - ph[(f + 1) % 3] - ph[(f + 2) % 3], longint'(m_pair),
                     24, WIDE_LIM, junk);
    lin[0] += mulq(corner[1], longint'(m_cross), 24, WIDE_LIM, junk);
    lin[1] += mulq(corner[0], longint'(m_cross), 24, WIDE_LIM, junk);

    q12 = mulq(ph[0], ph[1], 24, WIDE_LIM, junk);
    q13 = mulq(ph[0], ph[2], 24, WIDE_LIM, junk);
    q23 = mulq(ph[1], ph[2], 24, WIDE_LIM, junk);
    pp  = mulq(q12, ph[2], 24, WIDE_LIM, junk);
    p2  = mulq(pp, pp, 24, DEN_LIM, sat);
    kk  = mulq(longint'(m_soften), p2, 24, DEN_LIM, sat);
    dd  = (64'sd1 <<< 24) + kk;
    if (longint'(DEN_LIM) < dd) begin
      dd  = longint'(DEN_LIM);
      sat = 1'b1;
    end
    d2 = mulq(dd, dd, 24, WIDE_LIM, junk);
    recip = ((64'd1 << 62) + longint'(unsigned'(d2)) / 2) / longint'(unsigned'(d2));
    dp[0] = q23;
    dp[1] = q13;
    dp[2] = q12;
    for (int f = 0; f < 3; f++) begin
      tt  = mulq(pp, dp[f], 24, WIDE_LIM, junk);
      uu  = mulq(tt, longint'(recip), 38, WIDE_LIM, junk);
      ff  = mulq(-longint'(m_strength), uu, 24, TRIPLE_LIM, junk);
      acc = clip32(lin[f] + ff, sat);
      case (f)
        0: res.accel_zero = acc[31:0];
        1: res.accel_one  = acc[31:0];
        default: res.accel_two = acc[31:0];
      endcase
    end
    res.centre_row = 10'(r - 1);
    res.centre_col = 10'(c - 1);
    res.saturated  = sat;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    src_took = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COEF_X:          m_coef_x   = cfg_data[30:0];
          CFG_COEF_Y:          m_coef_y   = cfg_data[30:0];
          CFG_MASS_SQ:         m_mass_sq  = cfg_data[30:0];
          CFG_TRIPLE_STRENGTH: m_strength = cfg_data;
          CFG_TRIPLE_SOFTEN:   m_soften   = cfg_data[30:0];
          CFG_PAIR_GAIN:       m_pair     = cfg_data;
          CFG_CROSS_GAIN:      m_cross    = cfg_data;
          CFG_ROW_LENGTH:      m_row_len  = cfg_data[10:0];
          default: ;
        endcase
      end
      if (src_valid && !src_stall) begin
        src_took = 1'b1;
        n_accepted++;
        if (stencil_step(src_item, want))
          accel_q.push_back(typed_on ? typed_res : want);
      end
      if (res_valid && !res_stall) begin
        n_results++;
        if (res_item.saturated) n_sat++;
        if (accel_q.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, res_item);
          errors++;
        end else begin
          want = accel_q.pop_front();
          if (res_item.accel_zero !== want.accel_zero || res_item.accel_one !== want.accel_one
              || res_item.accel_two !== want.accel_two
              || res_item.centre_row !== want.centre_row
              || res_item.centre_col !== want.centre_col
              || res_item.saturated !== want.saturated) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, res_item);
            errors++;
          end
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic send(src_item_t it, bit typed, res_item_t tr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    typed_on  = typed;
    typed_res = tr;
    n_sent++;
    do @(negedge clk); while (!src_took);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (accel_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] cx, logic [31:0] cy, logic [31:0] ms,
                          logic [31:0] mu, logic [31:0] ka, logic [31:0] pg,
                          logic [31:0] cg, logic [31:0] rl);
    drain();
    write_reg(CFG_COEF_X, cx);
    write_reg(CFG_COEF_Y, cy);
    write_reg(CFG_MASS_SQ, ms);
    write_reg(CFG_TRIPLE_STRENGTH, mu);
    write_reg(CFG_TRIPLE_SOFTEN, ka);
    write_reg(CFG_PAIR_GAIN, pg);
    write_reg(CFG_CROSS_GAIN, cg);
    write_reg(CFG_ROW_LENGTH, rl);
  endtask

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom) >>> 5;
      5:       return $signed($urandom) >>> 1;
      6, 7:    return $urandom;
      8:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom) >>> 20;
    endcase
  endfunction

  // one frame in raster order; the odd stray frame_start restarts the counters
  task automatic run_frame(int n_points, bit noisy);
    src_item_t it;
    for (int i = 0; i < n_points; i++) begin
      it.field_zero  = pick_field();
      it.field_one   = pick_field();
      it.field_two   = pick_field();
      it.frame_start = (i == 0) || (noisy && $urandom_range(0, 60) == 0);
      send(it, 1'b0, '0);
    end
  endtask

  function automatic src_item_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c, bit fs);
    src_item_t it;
    it.field_zero  = a;
    it.field_one   = b;
    it.field_two   = c;
    it.frame_start = fs;
    return it;
  endfunction

  initial begin
    row_t      rw;
    res_item_t zero_res;
    int        len;
    logic [31:0] ext[5];
    rst = 1'b1;
    src_valid = 1'b0;
    src_item = '0;
    res_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    stall_left = 0;
    typed_on = 1'b0;
    typed_res = '0;
    m_coef_x = RST_COEF_X;
    m_coef_y = RST_COEF_Y;
    m_mass_sq = RST_MASS_SQ;
    m_strength = RST_TRIPLE_STRENGTH;
    m_soften = RST_TRIPLE_SOFTEN;
    m_pair = RST_PAIR_GAIN;
    m_cross = RST_CROSS_GAIN;
    m_row_len = RST_ROW_LENGTH;
    row_cnt = 0;
    col_cnt = 0;
    for (int f = 0; f < 3; f++)
      for (int k = 0; k < 27; k++) win[f][k / 9][(k / 3) % 3] = '0;
    for (int f = 0; f < 3; f++)
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win[f][k][j] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: a 3x3 zero grid, then extremes, then a frame restart mid-row
    write_reg(CFG_ROW_LENGTH, 32'd3);
    zero_res = '0;
    zero_res.centre_row = 10'd1;
    zero_res.centre_col = 10'd1;
    for (int i = 0; i < 9; i++) begin
      rw.it = mk('0, '0, '0, i == 0);
      rw.typed = (i == 8);
      rw.res = zero_res;
      dir_tab.push_back(rw);
    end
    ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'h01000000, 32'hffffffff};
    for (int i = 0; i < 9; i++) begin
      rw.it = mk(ext[i % 5], ext[(i + 1) % 5], ext[(i + 3) % 5], i == 0);
      rw.typed = 1'b0;
      dir_tab.push_back(rw);
    end
    for (int i = 0; i < 7; i++) begin
      rw.it = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, i == 1);
      rw.typed = 1'b0;
      dir_tab.push_back(rw);
    end
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    // settings at the extremes
    set_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, 32'd4);
    run_frame(16, 1'b0);
    set_regs(32'd0, 32'd0, 32'd0, 32'h7fffffff, 32'd0, 32'h7fffffff, 32'h80000000,
             32'hfffff800);
    run_frame(12, 1'b0);

    // longer rows with the cross-gradient term on: a full row of results
    set_regs(RST_COEF_X, RST_COEF_Y, RST_MASS_SQ, RST_TRIPLE_STRENGTH, RST_TRIPLE_SOFTEN,
             RST_PAIR_GAIN, 32'h00400000, 32'd40);
    run_frame(3 * 40, 1'b0);

    while (n_sent < 1100) begin
      len = $urandom_range(3, 8);
      if (n_sent > 950) quiet = 1'b1;
      set_regs($urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 6),
               $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 6),
               $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 8),
               $signed($urandom) >>> $urandom_range(0, 6),
               $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 8),
               $signed($urandom) >>> $urandom_range(2, 8),
               $urandom_range(0, 1) ? $signed($urandom) >>> $urandom_range(2, 8) : 32'd0,
               {$urandom_range(0, 1) ? 21'($urandom) : 21'd0, 11'(len)});
      for (int fr = 0; fr < 3; fr++) begin
        run_frame(len * $urandom_range(3, 6), 1'b1);
        // sender holds off until the pipeline is empty
        if (fr == 1) drain();
      end
    end

    src_valid <= 1'b0;
    while (accel_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("ran %0d grid points, %0d accepted, %0d results checked (%0d saturated)",
             n_sent, n_accepted, n_results, n_sat);
    $display("covered extreme and random register settings, rows of 3 to 40 points");
    if (errors == 0) begin
      $display("coupled_field_stencil_accel test passed");
    end else begin
      $display("coupled_field_stencil_accel test failed");
    end
    $finish;
  end

endmodule
